>>> rtl/core/assert_macros.svh
// Assertion helper macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/mfpc_pkg.sv
// ----------------------------------------------------------------------------
// mfpc_pkg
// Types, constants and helper functions for the Morton point compare unit.
// ----------------------------------------------------------------------------
package mfpc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LEVEL_W  = 9;
    localparam int unsigned MANT_W   = 23;
    localparam int unsigned EXP_BIAS = 127;
    localparam logic signed [LEVEL_W-1:0] LEVEL_NONE = -9'sd150;

    // Per-axis result handed from the axis unit to the merge stage
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      less;
    } t_axis_res;

    // Order key so that unsigned compare follows float order
    function automatic logic [WORD_W-1:0] order_key(input logic [WORD_W-1:0] a);
        order_key = a[WORD_W-1] ? ~a : (a | 32'h8000_0000);
    endfunction

    function automatic logic is_nan(input logic [WORD_W-1:0] a);
        is_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    endfunction

    // Float bits of 2^k
    function automatic logic [WORD_W-1:0] pow2_bits(input logic signed [LEVEL_W:0] k);
        logic signed [LEVEL_W:0] e;
        logic [7:0]              sh;
        e  = k + 10'sd127;
        sh = 8'(k + 10'sd149);
        if (k >= 10'sd128)       pow2_bits = 32'h7F80_0000;
        else if (k >= -10'sd126) pow2_bits = {1'b0, e[7:0], 23'd0};
        else if (k < -10'sd149)  pow2_bits = '0;
        else                     pow2_bits = 32'd1 << sh[4:0];
    endfunction

endpackage

>>> rtl/core/mfpc_axis.sv
// ----------------------------------------------------------------------------
// mfpc_axis
// Highest differing bit level and float less-than for one coordinate pair.
// ----------------------------------------------------------------------------
module mfpc_axis import mfpc_pkg::*; (
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output t_axis_res         o_res
);

    logic [7:0]        ea, eb, emax;
    logic [MANT_W-1:0] x;
    logic [4:0]        lead;
    logic              found;
    logic signed [LEVEL_W-1:0] level;
    logic              less;

    assign ea   = i_a[30:23];
    assign eb   = i_b[30:23];
    assign emax = (ea > eb) ? ea : eb;
    assign x    = i_a[MANT_W-1:0] ^ i_b[MANT_W-1:0];

    // Leading-one search over the mantissa XOR (priority encoder)
    always_comb begin
        lead  = '0;
        found = 1'b0;
        for (int j = 0; j < MANT_W; j++) begin
            if (x[j]) begin
                lead  = 5'(j);
                found = 1'b1;
            end
        end
    end

    // Level: larger exponent, or exponent less mantissa depth
    always_comb begin
        if (ea != eb) begin
            level = LEVEL_W'($signed({1'b0, emax}) - 10'sd127);
        end else if (found) begin
            level = LEVEL_W'($signed({2'b0, ea}) - 10'sd150
                             + $signed({5'b0, lead}));
        end else begin
            level = LEVEL_NONE;
        end
    end

    // IEEE less-than: NaN and zero pairs are false
    always_comb begin
        if (is_nan(i_a) || is_nan(i_b))                 less = 1'b0;
        else if (i_a[30:0] == '0 && i_b[30:0] == '0)    less = 1'b0;
        else less = order_key(i_a) < order_key(i_b);
    end

    assign o_res = '{level: level, less: less};

endmodule

>>> rtl/core/morton_float_point_compare_unit.sv
// ----------------------------------------------------------------------------
// morton_float_point_compare_unit
// Morton order compare of two 3D float points with difference level and volume.
//
// Channel | Dir | Content
// s_axis  | in  | tdata: p_x, p_y, p_z, q_x, q_y, q_z (192 bits)
// m_axis  | out | tdata: p_not_after_q, diff_level, volume_bits (48 bits)
//
// One item per cycle while the output is not stalled; input register, then result register.
// Throughput is set by the single compare pass between the two registers.
// Reset clears both valid flags. A stalled output holds its item while the
// input register still takes one more item; both stall only when both are full.
// ----------------------------------------------------------------------------
module morton_float_point_compare_unit import mfpc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // p_x, p_y, p_z, q_x, q_y, q_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata   // p_not_after_q, diff_level[8:0], volume_bits, pad
);

    logic [191:0] r_in;
    logic         r_in_vld;
    logic [47:0]  r_out;
    logic         r_out_vld;
    logic         out_take;
    t_axis_res    res [3];
    logic signed [LEVEL_W-1:0] best;
    logic                      rslt;
    logic [47:0]  n_out;

    assign out_take      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || out_take;

    // Axis units
    for (genvar g = 0; g < 3; g++) begin : g_axis
        mfpc_axis u_axis (
            .i_a   (r_in[g*32 +: 32]),
            .i_b   (r_in[(g+3)*32 +: 32]),
            .o_res (res[g])
        );
    end

    // Merge: first axis with a strictly greater level decides
    always_comb begin
        best = LEVEL_NONE;
        rslt = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (res[i].level > best) begin
                best = res[i].level;
                rslt = res[i].less;
            end
        end
        n_out = {6'd0, pow2_bits(10'(best) + 10'sd1), best, rslt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (out_take)      r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in <= s_axis_tdata;
        if (out_take && r_in_vld)           r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

>>> rtl/core/mfpc_checker.sv
// ----------------------------------------------------------------------------
// mfpc_checker
// Port-level checks on the compare unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mfpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // Stalled output holds
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // Input always ready while output is free
    `ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    // Accepted item reaches the output through the input and result registers when unstalled
    `ASSERT_IMPL(a_lat, i_clk, i_rst_n, $past(s_axis_tvalid && s_axis_tready, 2) && $past(m_axis_tready) && $past(i_rst_n, 2), m_axis_tvalid)
    // Padding bits stay zero on a valid item
    `ASSERT_IMPL(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[47:42] == 6'd0)

endmodule

bind morton_float_point_compare_unit mfpc_checker u_mfpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/morton_compare_checker.sv
// ----------------------------------------------------------------------------
// morton_compare_checker
// Watches both stream channels of the Morton point compare unit, predicts the
// order flag, difference level and volume of each accepted point pair and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module morton_compare_checker import mfpc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [191:0] i_in_data,    // p_x, p_y, p_z, q_x, q_y, q_z
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [47:0]  i_out_data,   // p_not_after_q, diff_level[8:0], volume_bits, pad
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      not_after;
        logic signed [LEVEL_W-1:0] level;
        logic [31:0]               volume;
    } t_order_res;

    t_order_res order_q[$];
    int         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = order_q.size();

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Level of highest differing bit on one axis; sign bit ignored
    function automatic int axis_diff_level(input logic [31:0] a, input logic [31:0] b);
        logic [22:0] x;
        x = a[22:0] ^ b[22:0];
        if (a[30:23] != b[30:23])
            return int'(a[30:23] > b[30:23] ? a[30:23] : b[30:23]) - 127;
        for (int j = 22; j >= 0; j--)
            if (x[j]) return int'(a[30:23]) - 127 - (23 - j);
        return -150;
    endfunction

    function automatic logic nan_bits(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    function automatic logic [31:0] sort_key(input logic [31:0] a);
        return a[31] ? ~a : {1'b1, a[30:0]};
    endfunction

    function automatic logic ieee_less(input logic [31:0] a, input logic [31:0] b);
        if (nan_bits(a) || nan_bits(b)) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
        return sort_key(a) < sort_key(b);
    endfunction

    function automatic logic [31:0] power_of_two(input int k);
        if (k >= 128) return 32'h7F80_0000;
        if (k >= -126) return {1'b0, 8'(k + 127), 23'd0};
        if (k < -149) return 32'd0;
        return 32'd1 << (k + 149);
    endfunction

    function automatic t_order_res predict_order(input logic [191:0] d);
        t_order_res r;
        int best, lv;
        logic [31:0] a, b;
        best = -150;
        r.not_after = 1'b1;
        for (int i = 0; i < 3; i++) begin
            a  = d[32*i +: 32];
            b  = d[32*(i+3) +: 32];
            lv = axis_diff_level(a, b);
            // strictly greater only: the first axis reaching a level decides
            if (lv > best) begin
                best = lv;
                r.not_after = ieee_less(a, b);
            end
        end
        r.level  = LEVEL_W'(best);
        r.volume = power_of_two(best + 1);
        return r;
    endfunction

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_order_res want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                order_q = {order_q, predict_order(i_in_data)};
            if (i_out_valid && i_out_ready) begin
                if (order_q.size() == 0) begin
                    report_mismatch("unexpected result", i_out_data[31:0], 32'd0);
                end else begin
                    want = order_q.pop_front();
                    if (i_out_data[0] !== want.not_after)
                        report_mismatch("p_not_after_q", 32'(i_out_data[0]),
                                        32'(want.not_after));
                    if (i_out_data[9:1] !== want.level)
                        report_mismatch("diff_level", 32'(i_out_data[9:1]),
                                        32'(want.level));
                    if (i_out_data[41:10] !== want.volume)
                        report_mismatch("volume_bits", i_out_data[41:10], want.volume);
                end
            end
        end
    end
endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Morton point compare unit: directed corner pairs (zeros,
// NaN, infinity, ties, lowest level, subnormal volumes) and then random pairs
// sharing exponents and mantissa prefixes, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS = 1430;
    localparam int IDLE_LIMIT   = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;   // p_x, p_y, p_z, q_x, q_y, q_z
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;        // p_not_after_q, diff_level, volume_bits, pad
    int           fail_count, pending, idle_cycles;

    always #5 i_clk = ~i_clk;

    morton_float_point_compare_unit i_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    morton_compare_checker i_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Mostly short gaps, sometimes long ones, sometimes none for a while
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_pair(input logic [31:0] px, py, pz, qx, qy, qz);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tdata  <= {qz, qy, qx, pz, py, px};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Random coordinate related to a base value so levels spread widely
    function automatic logic [31:0] near_value(input logic [31:0] base);
        int m;
        m = $urandom_range(0, 9);
        if (m < 2) return $urandom();
        if (m < 4) return {$urandom_range(0, 1) ? 1'b1 : base[31], base[30:0]};
        if (m < 6) return base ^ (32'd1 << $urandom_range(0, 22));
        if (m < 8) return {base[31:23], 23'($urandom())};
        if (m < 9) return base;
        return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(0, 255)), base[22:0]};
    endfunction

    function automatic logic [31:0] rand_coord();
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return {1'($urandom()), 8'hFF, 23'($urandom_range(0, 3))};
        if (m == 1) return {1'($urandom()), 8'h00, 23'($urandom())};
        return $urandom();
    endfunction

    // Result side stalls at random
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                              ($urandom_range(0, 99) < 20 && gap_len() == 0);
    end

    // Watchdog on cycles with no accepted item on either channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] a, b, c;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pairs
        send_pair(0, 0, 0, 0, 0, 0);                                // identical
        send_pair(32'h0000_0000, 0, 0, 32'h8000_0000, 0, 0);        // signed zeros
        send_pair(32'h0000_0001, 0, 0, 32'h0000_0000, 0, 0);        // lowest level
        send_pair(32'h0000_0002, 0, 0, 32'h0000_0000, 0, 0);        // subnormal volume
        send_pair(32'h7F80_0000, 0, 0, 32'h3F80_0000, 0, 0);        // infinity
        send_pair(32'h7FC0_0000, 0, 0, 32'h3F80_0000, 0, 0);        // NaN p
        send_pair(32'h3F80_0000, 0, 0, 32'hFFFF_FFFF, 0, 0);        // NaN q
        send_pair(32'h3F80_0000, 32'h4000_0000, 0,
                  32'h4000_0000, 32'h3F80_0000, 0);                 // level tie
        send_pair(0, 0, 32'h3F80_0000, 0, 0, 32'h4000_0000);        // z decides
        send_pair(0, 32'h7F7F_FFFF, 0, 0, 32'hFF7F_FFFF, 0);        // y, sign only
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_pair(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h7F00_0000, 0, 0, 32'h7E80_0000, 0, 0);        // level 127
        send_pair(32'h3F80_0000, 0, 0, 32'h3FC0_0000, 0, 0);        // mantissa top
        send_pair(32'hBF80_0000, 0, 0, 32'hBF80_0001, 0, 0);        // negative mant
        send_pair(32'h0080_0000, 0, 0, 32'h0000_0000, 0, 0);        // exp 1
        send_pair(32'h0040_0000, 0, 0, 32'h0000_0000, 0, 0);        // exp 0 top bit
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

        // Random pairs, mostly with related coordinates
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            a = rand_coord();
            b = rand_coord();
            c = rand_coord();
            if ($urandom_range(0, 4) == 0)
                send_pair(a, b, c, rand_coord(), rand_coord(), rand_coord());
            else
                send_pair(a, b, c, near_value(a), near_value(b), near_value(c));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
